// File: rtl/pee_pkg.sv
// ----------------------------------------------------------------------------
// pee_pkg
// Shared types and constants of the postfix expression evaluator: character
// codes, sequencer states and the command and status groups.
// ----------------------------------------------------------------------------
package pee_pkg;

	localparam int STACK_DEPTH_DEF = 16;
	localparam int SYM_W           = 8;
	localparam int DATA_W          = 32;
	localparam int DIV_CNT_W       = 5;
	localparam int OUT_TDATA_W     = 40;

	localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [SYM_W-1:0] CH_MUL   = 8'h2A;
	localparam logic [SYM_W-1:0] CH_DIV   = 8'h2F;
	localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_POP_R,
		ST_POP_L,
		ST_LATCH_L,
		ST_EXEC,
		ST_DIV_WAIT,
		ST_PUSH,
		ST_TOP_RD,
		ST_REPORT
	} pee_state_t;

	typedef struct packed {
		logic load_in;
		logic push_sym;
		logic pop;
		logic latch_rhs;
		logic latch_lhs;
		logic exec;
		logic div_capture;
		logic push_res;
		logic top_rd;
		logic report;
	} pee_cmd_t;

	typedef struct packed {
		logic is_op;
		logic is_div;
		logic last;
		logic div_done;
		logic out_free;
	} pee_sts_t;

endpackage

// File: rtl/pee_div.sv
// ----------------------------------------------------------------------------
// pee_div
// Signed 32-bit divider, truncating toward zero. Radix-2 restoring on the
// magnitudes, one quotient bit per cycle, sign applied at the end.
// ----------------------------------------------------------------------------
module pee_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [pee_pkg::DATA_W-1:0]  dividend,
	input  logic [pee_pkg::DATA_W-1:0]  divisor,
	output logic                        done,
	output logic [pee_pkg::DATA_W-1:0]  quotient
);
	import pee_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DATA_W:0]      rem_q;
	logic [DATA_W-1:0]    quo_q;
	logic [DATA_W-1:0]    dvs_q;
	logic                 neg_q;

	logic [DATA_W-1:0] mag_a;
	logic [DATA_W-1:0] mag_b;
	logic [DATA_W:0]   shifted;
	logic [DATA_W:0]   diff;

	assign mag_a   = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
	assign mag_b   = divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
	assign shifted = {rem_q[DATA_W-1:0], quo_q[DATA_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == '1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= mag_a;
			dvs_q <= mag_b;
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
		end else if (busy_q) begin
			// restore when the trial subtraction goes negative
			rem_q <= diff[DATA_W] ? shifted : diff;
			quo_q <= {quo_q[DATA_W-2:0], ~diff[DATA_W]};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (DATA_W'(0) - quo_q) : quo_q;

endmodule

// File: rtl/pee_dp.sv
// ----------------------------------------------------------------------------
// pee_dp
// Datapath: input register, operand stack memory, operand registers,
// arithmetic unit with divider, sticky flags and the output register.
// ----------------------------------------------------------------------------
module pee_dp #(
	parameter int STACK_DEPTH = pee_pkg::STACK_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [pee_pkg::SYM_W-1:0]       in_symbol,
	input  logic                            in_last,
	input  pee_pkg::pee_cmd_t               cmd,
	output pee_pkg::pee_sts_t               sts,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [pee_pkg::OUT_TDATA_W-1:0] out_data
);
	import pee_pkg::*;

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [DATA_W-1:0] mem [STACK_DEPTH];
	logic [DATA_W-1:0] rdata_q;

	logic [SYM_W-1:0]  sym_q;
	logic              last_q;
	logic [CW-1:0]     count_q;
	logic              pop_empty_q;
	logic [DATA_W-1:0] lhs_q;
	logic [DATA_W-1:0] rhs_q;
	logic [DATA_W-1:0] res_q;
	logic              uf_q;
	logic              of_q;
	logic              dz_q;
	logic              out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic              is_op;
	logic              is_div;
	logic              stack_empty;
	logic              stack_full;
	logic              push;
	logic [DATA_W-1:0] push_val;
	logic              rd_en;
	logic [CW-1:0]     top_idx;
	logic [DATA_W-1:0] popped;
	logic [DATA_W-1:0] arith;
	logic              div_start;
	logic              div_done;
	logic [DATA_W-1:0] div_quo;

	assign is_op  = (sym_q == CH_PLUS) || (sym_q == CH_MINUS) ||
	                (sym_q == CH_MUL) || (sym_q == CH_DIV);
	assign is_div = (sym_q == CH_DIV);

	assign stack_empty = (count_q == '0);
	assign stack_full  = (count_q == CW'(STACK_DEPTH));
	assign top_idx     = count_q - CW'(1);

	assign push     = cmd.push_sym | cmd.push_res;
	assign push_val = cmd.push_sym ? ({{(DATA_W-SYM_W){1'b0}}, sym_q} - {{(DATA_W-SYM_W){1'b0}}, CH_ZERO})
	                               : res_q;
	assign rd_en    = (cmd.pop & ~stack_empty) | cmd.top_rd;
	assign popped   = pop_empty_q ? '1 : rdata_q;

	always_comb begin
		case (sym_q)
			CH_PLUS:  arith = lhs_q + rhs_q;
			CH_MINUS: arith = lhs_q - rhs_q;
			CH_MUL:   arith = lhs_q * rhs_q;
			default:  arith = '0;
		endcase
	end

	assign div_start = cmd.exec & is_div;

	pee_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (lhs_q),
		.divisor  (rhs_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// stack memory, registered read
	always_ff @(posedge clk) begin
		if (push && !stack_full) begin
			mem[count_q[AW-1:0]] <= push_val;
		end
		if (rd_en) begin
			rdata_q <= mem[top_idx[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			uf_q        <= 1'b0;
			of_q        <= 1'b0;
			dz_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.report) begin
				count_q <= '0;
				uf_q    <= 1'b0;
				of_q    <= 1'b0;
				dz_q    <= 1'b0;
			end else begin
				if (push) begin
					if (stack_full) begin
						of_q <= 1'b1;
					end else begin
						count_q <= count_q + CW'(1);
					end
				end
				if (cmd.pop) begin
					if (stack_empty) begin
						uf_q <= 1'b1;
					end else begin
						count_q <= top_idx;
					end
				end
				if (cmd.div_capture && (rhs_q == '0)) begin
					dz_q <= 1'b1;
				end
			end
			if (cmd.report) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			sym_q  <= in_symbol;
			last_q <= in_last;
		end
		if (cmd.pop) begin
			pop_empty_q <= stack_empty;
		end
		if (cmd.latch_rhs) begin
			rhs_q <= popped;
		end
		if (cmd.latch_lhs) begin
			lhs_q <= popped;
		end
		if (cmd.exec && !is_div) begin
			res_q <= arith;
		end else if (cmd.div_capture) begin
			res_q <= (rhs_q == '0) ? '0 : div_quo;
		end
		if (cmd.report) begin
			out_data_q <= {{(OUT_TDATA_W-DATA_W-4){1'b0}}, dz_q, of_q, uf_q, stack_empty,
			               stack_empty ? {DATA_W{1'b1}} : rdata_q};
		end
	end

	assign sts.is_op    = is_op;
	assign sts.is_div   = is_div;
	assign sts.last     = last_q;
	assign sts.div_done = div_done;
	assign sts.out_free = ~out_valid_q | out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// File: rtl/pee_ctrl.sv
// ----------------------------------------------------------------------------
// pee_ctrl
// Sequencer: operators go through decode, pops, execute and push; operands
// are pushed in decode; the last one adds the top-of-stack read and report.
// ----------------------------------------------------------------------------
module pee_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pee_pkg::pee_sts_t sts,
	output pee_pkg::pee_cmd_t cmd
);
	import pee_pkg::*;

	pee_state_t state_q;
	pee_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (sts.is_op) begin
					state_nxt = ST_POP_R;
				end else begin
					state_nxt = sts.last ? ST_TOP_RD : ST_IDLE;
				end
			end
			ST_POP_R:   state_nxt = ST_POP_L;
			ST_POP_L:   state_nxt = ST_LATCH_L;
			ST_LATCH_L: state_nxt = ST_EXEC;
			ST_EXEC:    state_nxt = sts.is_div ? ST_DIV_WAIT : ST_PUSH;
			ST_DIV_WAIT: begin
				if (sts.div_done) begin
					state_nxt = ST_PUSH;
				end
			end
			ST_PUSH:   state_nxt = sts.last ? ST_TOP_RD : ST_IDLE;
			ST_TOP_RD: state_nxt = ST_REPORT;
			ST_REPORT: begin
				// hold until the output register can take the request
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			ST_DECODE:  cmd.push_sym = ~sts.is_op;
			ST_POP_R:   cmd.pop = 1'b1;
			ST_POP_L: begin
				cmd.pop       = 1'b1;
				cmd.latch_rhs = 1'b1;
			end
			ST_LATCH_L:  cmd.latch_lhs = 1'b1;
			ST_EXEC:     cmd.exec = 1'b1;
			ST_DIV_WAIT: cmd.div_capture = sts.div_done;
			ST_PUSH:     cmd.push_res = 1'b1;
			ST_TOP_RD:   cmd.top_rd = 1'b1;
			ST_REPORT:   cmd.report = sts.out_free;
			default:     cmd = '0;
		endcase
	end

endmodule

// File: rtl/postfix_expression_evaluator_top.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_top
// Postfix evaluator, one character per request, one result per expression.
// Operand characters are pushed at decode; + - * pop both operands, execute
// and push; / also waits for the 32 iterations of the radix-2 divider. The
// final character then adds the top-of-stack read and a registered report.
// Reset clears the sequencer, stack count, flags and output valid; stack
// words are not cleared and are only used below the count.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_top #(
	parameter int STACK_DEPTH = pee_pkg::STACK_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [pee_pkg::SYM_W-1:0]       s_tdata,  // symbol[7:0]
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// value[31:0], empty_at_end[32], underflow_seen[33], overflow_seen[34],
	// divide_by_zero_seen[35], zero fill[39:36]
	output logic [pee_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import pee_pkg::*;

	pee_cmd_t cmd;
	pee_sts_t sts;

	pee_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pee_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_symbol (s_tdata),
		.in_last   (s_tlast),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

// File: rtl/pee_chk.sv
// ----------------------------------------------------------------------------
// pee_chk
// Port-level checks of the postfix evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module pee_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            s_tlast,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [pee_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import pee_pkg::*;

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one character at a time: no request taken in the cycle after one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while previous one in progress");

	// empty stack reports minus one
	a_empty_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[DATA_W] |-> m_tdata[DATA_W-1:0] == {DATA_W{1'b1}})
		else $error("empty stack with value other than minus one");

	// an accepted non-final character is not directly followed by a rising result
	a_result_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tlast |=> !$rose(m_tvalid))
		else $error("result without a final character");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_TDATA_W-1:DATA_W+4] == '0)
		else $error("fill bits of result not zero");

endmodule

bind postfix_expression_evaluator_top pee_chk u_pee_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
